// ===== src/shpl_pkg.sv =====
// Shared types, constants and helpers for the serial hex page loader.
// Used by every module of the block; depends on nothing.
package shpl_pkg;

  localparam logic [31:0] ResetTermination = 32'hDEAD_C0DE;
  localparam logic [7:0]  NewlineChar      = 8'h0A;
  localparam logic [3:0]  WordDigits       = 4'd8;
  localparam logic [3:0]  ByteDigits       = 4'd2;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_PAGE_OK = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_FAIL    = 2'd3
  } kind_e;

  typedef struct packed {
    logic step;
    logic byte_field;
  } field_ctl_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
    logic        bad;
  } field_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [30:0] page_number;
    logic [7:0]  received_parity;
    logic [7:0]  computed_parity;
    logic [31:0] received_termination;
    logic        format_error;
  } result_t;

  function automatic logic hex_ok(input logic [7:0] c);
    hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
    end
    hex_digit = t[3:0];
  endfunction

endpackage

// ===== src/serial_hex_page_loader.sv =====
// Top level of the serial hex page loader: field parser, page sequencer, result queue.
// Depends on shpl_pkg, shpl_field, shpl_seq and shpl_outq.
//
// Channel  Direction  Handshake                   Payload
// input    in         in_valid_i / in_ready_o     rx_char_i
// output   out        out_valid_o / out_ready_i   kind_o .. format_error_o
// config   in         cfg_we_i                    cfg_wdata_i
//
// One character is accepted per cycle while in_ready_o is high; its result, if any,
// is visible the next cycle when no earlier result is still waiting.
// The result path holds two items, so input stalls only when both slots are full.
// Reset clears the parser, the sequencer and the result queue at once; the
// termination word returns to its default.
// After a load completes or fails every further character is accepted and dropped.
module serial_hex_page_loader (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] address_o,
  output logic [7:0]  data_byte_o,
  output logic [30:0] page_number_o,
  output logic [7:0]  received_parity_o,
  output logic [7:0]  computed_parity_o,
  output logic [31:0] received_termination_o,
  output logic        format_error_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  shpl_pkg::field_ctl_t field_ctl;
  shpl_pkg::field_t     field;
  shpl_pkg::result_t    res, head;
  logic                 res_valid;
  logic                 fire;

  assign fire = in_valid_i & in_ready_o;

  shpl_field u_field (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_char_i (rx_char_i),
    .ctl_i     (field_ctl),
    .field_o   (field)
  );

  shpl_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .field_i     (field),
    .ctl_o       (field_ctl),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  shpl_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .ready_o     (in_ready_o),
    .valid_o     (out_valid_o),
    .pop_ready_i (out_ready_i),
    .data_o      (head)
  );

  assign kind_o                 = head.kind;
  assign address_o              = head.address;
  assign data_byte_o            = head.data_byte;
  assign page_number_o          = head.page_number;
  assign received_parity_o      = head.received_parity;
  assign computed_parity_o      = head.computed_parity;
  assign received_termination_o = head.received_termination;
  assign format_error_o         = head.format_error;

endmodule

// ===== src/shpl_field.sv =====
// Hex field parser: collects digits of a word or byte field and checks its terminator.
// Depends on shpl_pkg.
module shpl_field (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          rx_char_i,
  input  shpl_pkg::field_ctl_t ctl_i,
  output shpl_pkg::field_t    field_o
);

  logic [3:0]  char_index_q, char_index_d;
  logic [31:0] value_q, value_d;
  logic        bad_q, bad_d;
  logic [3:0]  digits;
  logic        term_ok;

  assign digits  = ctl_i.byte_field ? shpl_pkg::ByteDigits : shpl_pkg::WordDigits;
  assign term_ok = (rx_char_i == shpl_pkg::NewlineChar);

  assign field_o.done  = (char_index_q >= digits);
  assign field_o.value = term_ok ? value_q : 32'h0;
  assign field_o.bad   = bad_q | ~term_ok;

  always_comb begin
    char_index_d = char_index_q;
    value_d      = value_q;
    bad_d        = bad_q;
    if (ctl_i.step) begin
      if (field_o.done) begin
        char_index_d = 4'd0;
        value_d      = 32'h0;
        bad_d        = 1'b0;
      end else begin
        char_index_d = char_index_q + 4'd1;
        value_d      = {value_q[27:0], shpl_pkg::hex_digit(rx_char_i)};
        bad_d        = bad_q | ~shpl_pkg::hex_ok(rx_char_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_index_q <= 4'd0;
      value_q      <= 32'h0;
      bad_q        <= 1'b0;
    end else begin
      char_index_q <= char_index_d;
      value_q      <= value_d;
      bad_q        <= bad_d;
    end
  end

endmodule

// ===== src/shpl_seq.sv =====
// Page sequencer: walks the load stream, checks parity and termination, builds results.
// Depends on shpl_pkg; fed by shpl_field.
module shpl_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  input  shpl_pkg::field_t     field_i,
  output shpl_pkg::field_ctl_t ctl_o,
  output logic                 res_valid_o,
  output shpl_pkg::result_t    res_o
);

  typedef enum logic [2:0] {
    PH_COUNT  = 3'd0,
    PH_SIZE   = 3'd1,
    PH_BASE   = 3'd2,
    PH_DATA   = 3'd3,
    PH_PARITY = 3'd4,
    PH_TERM   = 3'd5,
    PH_START  = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] exp_term_q, exp_term_d;
  logic [31:0] total_q, total_d;
  logic [31:0] page_bytes_q, page_bytes_d;
  logic [30:0] pages_left_q, pages_left_d;
  logic [31:0] page_base_q, page_base_d;
  logic [31:0] byte_index_q, byte_index_d;
  logic [7:0]  parity_q, parity_d;
  logic [7:0]  prx_q, prx_d;
  logic        finished_q, finished_d;
  logic [31:0] index_next;
  logic [30:0] left_dec;

  assign ctl_o.step       = fire_i & ~finished_q;
  assign ctl_o.byte_field = (phase_q == PH_DATA) || (phase_q == PH_PARITY);
  assign index_next       = byte_index_q + 32'd1;
  assign left_dec         = pages_left_q - 31'd1;

  always_comb begin
    phase_d      = phase_q;
    exp_term_d   = cfg_we_i ? cfg_wdata_i : exp_term_q;
    total_d      = total_q;
    page_bytes_d = page_bytes_q;
    pages_left_d = pages_left_q;
    page_base_d  = page_base_q;
    byte_index_d = byte_index_q;
    parity_d     = parity_q;
    prx_d        = prx_q;
    finished_d   = finished_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    if (ctl_o.step && field_i.done) begin
      res_o.format_error = field_i.bad;
      unique case (phase_q)
        PH_COUNT: begin
          total_d = field_i.value;
          phase_d = PH_SIZE;
        end
        PH_SIZE: begin
          page_bytes_d = field_i.value;
          if (total_q == 32'h0 || total_q[31]) begin
            pages_left_d = 31'd0;
            phase_d      = PH_START;
          end else begin
            pages_left_d = total_q[30:0];
            phase_d      = PH_BASE;
          end
        end
        PH_BASE: begin
          page_base_d  = field_i.value;
          byte_index_d = 32'h0;
          parity_d     = 8'h0;
          phase_d      = (page_bytes_q == 32'h0) ? PH_PARITY : PH_DATA;
        end
        PH_DATA: begin
          res_valid_o     = 1'b1;
          res_o.kind      = shpl_pkg::KIND_WRITE;
          res_o.address   = page_base_q + byte_index_q;
          res_o.data_byte = field_i.value[7:0];
          parity_d        = parity_q ^ field_i.value[7:0];
          byte_index_d    = index_next;
          if (index_next == page_bytes_q) begin
            phase_d = PH_PARITY;
          end
        end
        PH_PARITY: begin
          prx_d   = field_i.value[7:0];
          phase_d = PH_TERM;
        end
        PH_TERM: begin
          res_valid_o = 1'b1;
          if (prx_q == parity_q && field_i.value == exp_term_q) begin
            pages_left_d      = left_dec;
            res_o.kind        = shpl_pkg::KIND_PAGE_OK;
            res_o.page_number = total_q[30:0] - left_dec;
            phase_d           = (left_dec == 31'd0) ? PH_START : PH_BASE;
          end else begin
            res_o.kind                 = shpl_pkg::KIND_FAIL;
            res_o.page_number          = pages_left_q;
            res_o.received_parity      = prx_q;
            res_o.computed_parity      = parity_q;
            res_o.received_termination = field_i.value;
            finished_d                 = 1'b1;
          end
        end
        default: begin
          // The start address field, which also covers the unused phase code.
          res_valid_o   = 1'b1;
          res_o.kind    = shpl_pkg::KIND_DONE;
          res_o.address = field_i.value;
          finished_d    = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_COUNT;
      exp_term_q   <= shpl_pkg::ResetTermination;
      total_q      <= 32'h0;
      page_bytes_q <= 32'h0;
      pages_left_q <= 31'd0;
      page_base_q  <= 32'h0;
      byte_index_q <= 32'h0;
      parity_q     <= 8'h0;
      prx_q        <= 8'h0;
      finished_q   <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      exp_term_q   <= exp_term_d;
      total_q      <= total_d;
      page_bytes_q <= page_bytes_d;
      pages_left_q <= pages_left_d;
      page_base_q  <= page_base_d;
      byte_index_q <= byte_index_d;
      parity_q     <= parity_d;
      prx_q        <= prx_d;
      finished_q   <= finished_d;
    end
  end

endmodule

// ===== src/shpl_outq.sv =====
// Two-entry result register with skid slot between the sequencer and the output channel.
// Depends on shpl_pkg.
module shpl_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  shpl_pkg::result_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output shpl_pkg::result_t data_o
);

  logic              v0_q, v0_d, v1_q, v1_d;
  shpl_pkg::result_t e0_q, e0_d, e1_q, e1_d;
  logic              pop;

  assign ready_o = ~v1_q;
  assign valid_o = v0_q;
  assign data_o  = e0_q;
  assign pop     = v0_q & pop_ready_i;

  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    e0_d = e0_q;
    e1_d = e1_q;
    if (pop) begin
      v0_d = v1_q;
      e0_d = e1_q;
      v1_d = 1'b0;
    end
    if (push_i) begin
      if (!v0_d) begin
        v0_d = 1'b1;
        e0_d = data_i;
      end else begin
        v1_d = 1'b1;
        e1_d = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

endmodule

// ===== src/shpl_checker.sv =====
// Port-level checks for the serial hex page loader, attached by bind.
// Depends on shpl_pkg and serial_hex_page_loader.
module shpl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [31:0] address_o,
  input logic [7:0]  data_byte_o,
  input logic [30:0] page_number_o,
  input logic [31:0] received_termination_o
);

  logic last_kind;

  assign last_kind = (kind_o == shpl_pkg::KIND_DONE) || (kind_o == shpl_pkg::KIND_FAIL);

  // A waiting item is not withdrawn.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item withdrawn before accepted");

  // Nothing follows the final report.
  a_last_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_kind |=> !out_valid_o)
    else $error("item after load complete or failed");

  a_write_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == shpl_pkg::KIND_WRITE
    |-> page_number_o == 31'd0 && received_termination_o == 32'h0)
    else $error("byte write carries page report fields");

  a_page_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == shpl_pkg::KIND_PAGE_OK
    |-> address_o == 32'h0 && data_byte_o == 8'h0)
    else $error("page report carries write fields");

endmodule

bind serial_hex_page_loader shpl_checker u_shpl_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .out_valid_o            (out_valid_o),
  .out_ready_i            (out_ready_i),
  .kind_o                 (kind_o),
  .address_o              (address_o),
  .data_byte_o            (data_byte_o),
  .page_number_o          (page_number_o),
  .received_termination_o (received_termination_o)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for serial_hex_page_loader: drives one full page load as
// characters, predicts every memory write and page report, and compares results.
// Depends on shpl_pkg and the serial_hex_page_loader RTL.
module tb_top;

  localparam int CycleLimit = 200000;
  localparam logic [7:0] CharZero = "0";
  localparam logic [7:0] CharNine = "9";
  localparam logic [7:0] CharLowA = "a";
  localparam logic [7:0] CharLowF = "f";
  localparam logic [7:0] CharUpA  = "A";
  localparam logic [7:0] CharUpF  = "F";

  typedef enum logic [2:0] {
    LD_COUNT, LD_SIZE, LD_BASE, LD_DATA, LD_PARITY, LD_TERM, LD_START
  } load_phase_e;

  typedef enum {CLEAN, BAD_DIGIT, BAD_END, ZERO_SUBST} field_noise_e;
  typedef enum {LOAD_OK, FAIL_PARITY, FAIL_TERM, FAIL_BOTH} load_plan_e;

  typedef struct {
    logic [63:0]       text;
    int                ndig;
    logic [7:0]        term;
    bit                typed;
    shpl_pkg::result_t want;
  } field_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_char_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  kind_o;
  logic [31:0] address_o;
  logic [7:0]  data_byte_o;
  logic [30:0] page_number_o;
  logic [7:0]  received_parity_o;
  logic [7:0]  computed_parity_o;
  logic [31:0] received_termination_o;
  logic        format_error_o;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  // Loader state as the predictor sees it.
  load_phase_e ld_phase;
  logic [3:0]  hex_cnt;
  logic [31:0] hex_acc;
  bit          hex_bad;
  logic [31:0] page_total;
  logic [31:0] page_len;
  logic [30:0] pages_left;
  logic [31:0] page_base;
  logic [31:0] byte_idx;
  logic [7:0]  xor_acc;
  logic [7:0]  parity_sent;
  bit          load_over;
  logic [31:0] term_word;

  shpl_pkg::result_t loader_events_q[$];
  bit      calm;
  bit      pressure_done = 1'b0;
  int      results_seen = 0;
  int      errors = 0;
  int      chars_sent;
  int      cfg_writes;
  int      cycles = 0;

  serial_hex_page_loader i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .rx_char_i             (rx_char_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .kind_o                (kind_o),
    .address_o             (address_o),
    .data_byte_o           (data_byte_o),
    .page_number_o         (page_number_o),
    .received_parity_o     (received_parity_o),
    .computed_parity_o     (computed_parity_o),
    .received_termination_o(received_termination_o),
    .format_error_o        (format_error_o),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic [3:0] char_nibble(input logic [7:0] c, output bit ok);
    ok = 1'b1;
    if (c >= CharZero && c <= CharNine) return 4'(c - CharZero);
    if (c >= CharLowA && c <= CharLowF) return 4'(c - CharLowA + 8'd10);
    if (c >= CharUpA && c <= CharUpF) return 4'(c - CharUpA + 8'd10);
    ok = 1'b0;
    return 4'h0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CharZero + {4'h0, n};
    return (($urandom_range(0, 1) == 1) ? CharLowA : CharUpA) + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] c;
    bit ok;
    do begin
      c = 8'($urandom_range(0, 255));
      void'(char_nibble(c, ok));
    end while (ok);
    return c;
  endfunction

  function automatic logic [7:0] pick_not_newline();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == shpl_pkg::NewlineChar);
    return c;
  endfunction

  function automatic field_noise_e rare_noise();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return BAD_DIGIT;
    if (r == 2) return BAD_END;
    return CLEAN;
  endfunction

  function automatic shpl_pkg::result_t write_at(input logic [31:0] a, input logic [7:0] d,
                                                 input logic fe);
    shpl_pkg::result_t ev;
    ev = '0;
    ev.kind = shpl_pkg::KIND_WRITE;
    ev.address = a;
    ev.data_byte = d;
    ev.format_error = fe;
    return ev;
  endfunction

  // Advances the loader state by one character and returns 1 with the event
  // it causes, if any.
  function automatic bit predict_loader_event(input logic [7:0] c,
                                              output shpl_pkg::result_t ev);
    logic [3:0]  digits;
    logic [3:0]  nib;
    logic [31:0] val;
    bit          bad;
    bit          ok;
    ev = '0;
    if (load_over) return 1'b0;
    digits = (ld_phase == LD_DATA || ld_phase == LD_PARITY) ?
             shpl_pkg::ByteDigits : shpl_pkg::WordDigits;
    if (hex_cnt < digits) begin
      nib = char_nibble(c, ok);
      if (!ok) hex_bad = 1'b1;
      hex_acc = {hex_acc[27:0], nib};
      hex_cnt = hex_cnt + 4'd1;
      return 1'b0;
    end
    val = hex_acc;
    bad = hex_bad;
    if (c != shpl_pkg::NewlineChar) begin
      val = '0;
      bad = 1'b1;
    end
    hex_acc = '0;
    hex_cnt = '0;
    hex_bad = 1'b0;
    ev.format_error = bad;
    case (ld_phase)
      LD_COUNT: begin
        page_total = val;
        ld_phase = LD_SIZE;
        return 1'b0;
      end
      LD_SIZE: begin
        page_len = val;
        if (page_total == '0 || page_total[31]) begin
          pages_left = '0;
          ld_phase = LD_START;
        end else begin
          pages_left = page_total[30:0];
          ld_phase = LD_BASE;
        end
        return 1'b0;
      end
      LD_BASE: begin
        page_base = val;
        byte_idx = '0;
        xor_acc = '0;
        if (page_len == '0) ld_phase = LD_PARITY;
        else ld_phase = LD_DATA;
        return 1'b0;
      end
      LD_DATA: begin
        ev.kind = shpl_pkg::KIND_WRITE;
        ev.address = page_base + byte_idx;
        ev.data_byte = val[7:0];
        xor_acc ^= val[7:0];
        byte_idx = byte_idx + 32'd1;
        if (byte_idx == page_len) ld_phase = LD_PARITY;
        return 1'b1;
      end
      LD_PARITY: begin
        parity_sent = val[7:0];
        ld_phase = LD_TERM;
        return 1'b0;
      end
      LD_TERM: begin
        if (parity_sent == xor_acc && val == term_word) begin
          pages_left = pages_left - 31'd1;
          ev.kind = shpl_pkg::KIND_PAGE_OK;
          ev.page_number = page_total[30:0] - pages_left;
          if (pages_left == '0) ld_phase = LD_START;
          else ld_phase = LD_BASE;
        end else begin
          ev.kind = shpl_pkg::KIND_FAIL;
          ev.page_number = pages_left;
          ev.received_parity = parity_sent;
          ev.computed_parity = xor_acc;
          ev.received_termination = val;
          load_over = 1'b1;
        end
        return 1'b1;
      end
      default: begin
        ev.kind = shpl_pkg::KIND_DONE;
        ev.address = val;
        load_over = 1'b1;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input bit typed,
                           input shpl_pkg::result_t want);
    shpl_pkg::result_t ev;
    in_valid_i <= 1'b1;
    rx_char_i  <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (predict_loader_event(c, ev) && !typed) loader_events_q.push_back(ev);
    if (typed) loader_events_q.push_back(want);
    chars_sent++;
    if (!calm && (chars_sent / 128) % 3 != 2 && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic send_field(input logic [31:0] v, input int ndig, input field_noise_e noise);
    int bad_pos;
    logic [3:0] nib;
    logic [7:0] c;
    bad_pos = $urandom_range(0, ndig - 1);
    for (int k = ndig - 1; k >= 0; k--) begin
      nib = v[4*k +: 4];
      c = hex_char(nib);
      if ((noise == BAD_DIGIT && k == bad_pos) ||
          (noise == ZERO_SUBST && nib == 4'h0 && $urandom_range(0, 1) == 1)) begin
        c = pick_non_hex();
      end
      send_char(c, 1'b0, '0);
    end
    send_char((noise == BAD_END) ? pick_not_newline() : shpl_pkg::NewlineChar, 1'b0, '0);
  endtask

  task automatic write_termination(input logic [31:0] v);
    in_valid_i <= 1'b0;
    while (loader_events_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    term_word = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    shpl_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (loader_events_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d", $time, kind_o);
      end else begin
        want = loader_events_q.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("address", want.address, address_o);
        check_field("data_byte", want.data_byte, data_byte_o);
        check_field("page_number", want.page_number, page_number_o);
        check_field("received_parity", want.received_parity, received_parity_o);
        check_field("computed_parity", want.computed_parity, computed_parity_o);
        check_field("received_termination", want.received_termination,
                    received_termination_o);
        check_field("format_error", want.format_error, format_error_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("serial_hex_page_loader test failed");
      $finish;
    end
  end

  initial begin : result_drain
    int hold;
    out_ready_i = 1'b0;
    hold = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (!pressure_done && results_seen >= 30) begin
        pressure_done = 1'b1;
        hold = 299;
        out_ready_i <= 1'b0;
      end else if (!calm && (cycles / 256) % 3 != 1 && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(0, 7);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : char_source
    field_row_t   intro_rows[6];
    load_plan_e   plan;
    logic [31:0]  base;
    int           pages_done;
    int           r;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    rx_char_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    ld_phase = LD_COUNT;
    hex_cnt = '0;
    hex_acc = '0;
    hex_bad = 1'b0;
    page_total = '0;
    page_len = '0;
    pages_left = '0;
    page_base = '0;
    byte_idx = '0;
    xor_acc = '0;
    parity_sent = '0;
    load_over = 1'b0;
    term_word = shpl_pkg::ResetTermination;
    calm = 1'b0;
    chars_sent = 0;
    cfg_writes = 0;
    intro_rows = '{
      '{"00000024", 8, shpl_pkg::NewlineChar, 1'b0, '0},
      '{"0000000C", 8, shpl_pkg::NewlineChar, 1'b0, '0},
      '{"fFfFfFfE", 8, shpl_pkg::NewlineChar, 1'b0, '0},
      '{"FF", 2, shpl_pkg::NewlineChar, 1'b1, write_at(32'hFFFF_FFFE, 8'hFF, 1'b0)},
      '{"g5", 2, shpl_pkg::NewlineChar, 1'b1, write_at(32'hFFFF_FFFF, 8'h05, 1'b1)},
      '{"7B", 2, "x", 1'b1, write_at(32'h0000_0000, 8'h00, 1'b1)}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_termination($urandom);

    foreach (intro_rows[i]) begin
      for (int k = 0; k < intro_rows[i].ndig; k++) begin
        send_char(intro_rows[i].text[8*(intro_rows[i].ndig-1-k) +: 8], 1'b0, '0);
      end
      send_char(intro_rows[i].term, intro_rows[i].typed, intro_rows[i].want);
    end

    plan = ($urandom_range(0, 1) == 1) ? LOAD_OK : load_plan_e'($urandom_range(1, 3));
    while (!load_over) begin
      calm = (pages_left <= 31'd3);
      case (ld_phase)
        LD_BASE: begin
          pages_done = int'(page_total[30:0] - pages_left);
          if (pages_done % 4 == 0) begin
            case ((pages_done / 4) % 4)
              0: write_termination(32'hFFFF_FFFF);
              1: write_termination(32'h0000_0000);
              2: write_termination($urandom);
              default: write_termination(shpl_pkg::ResetTermination);
            endcase
          end
          r = $urandom_range(0, 7);
          if (r < 2) base = 32'hFFFF_FFFF - $urandom_range(0, 11);
          else if (r == 2) base = '0;
          else base = $urandom;
          send_field(base, 8, rare_noise());
        end
        LD_DATA: send_field($urandom_range(0, 255), 2, rare_noise());
        LD_PARITY: begin
          if (pages_left == 31'd1 && (plan == FAIL_PARITY || plan == FAIL_BOTH)) begin
            send_field({24'h0, xor_acc ^ 8'($urandom_range(1, 255))}, 2, CLEAN);
          end else begin
            send_field({24'h0, xor_acc}, 2,
                       ($urandom_range(0, 3) == 0) ? ZERO_SUBST : CLEAN);
          end
        end
        LD_TERM: begin
          if (pages_left == 31'd1 && (plan == FAIL_TERM || plan == FAIL_BOTH)) begin
            send_field(term_word ^ ($urandom | 32'h1), 8, CLEAN);
          end else if (term_word == '0 && $urandom_range(0, 2) == 0) begin
            send_field('0, 8, BAD_END);
          end else begin
            send_field(term_word, 8, ($urandom_range(0, 3) == 0) ? ZERO_SUBST : CLEAN);
          end
        end
        default: begin
          r = $urandom_range(0, 3);
          send_field($urandom, 8, (r == 0) ? BAD_DIGIT : ((r == 1) ? BAD_END : CLEAN));
        end
      endcase
    end

    // The block must swallow everything after the load has ended.
    for (int i = 0; i < 20; i++) send_char(8'($urandom_range(0, 255)), 1'b0, '0);

    in_valid_i <= 1'b0;
    while (loader_events_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d characters of a %0d-page load with %0d-byte pages; %0d results checked.",
             chars_sent, page_total, page_len, results_seen);
    $display("Termination word rewritten %0d times; load plan %s; %0d mismatches.",
             cfg_writes, plan.name(), errors);
    if (errors == 0) begin
      $display("serial_hex_page_loader test passed");
    end else begin
      $display("serial_hex_page_loader test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/shpl_pkg.sv
src/shpl_field.sv
src/shpl_seq.sv
src/shpl_outq.sv
src/serial_hex_page_loader.sv
src/shpl_checker.sv
tb/tb_top.sv
